// ===== sv/dmkt_pkg.sv =====
package dmkt_pkg;

  localparam int KeyW         = 31;
  localparam int PayW         = 64;
  localparam int SizeW        = 11;
  localparam int ModeW        = 2;
  localparam int SlotsDefault = 1024;
  localparam int QDepth       = 2;
  localparam int PaddrW       = 3;
  localparam int DataW        = 32;

  // The remainder unit works on the key widened to a whole number of steps.
  localparam int DivW          = KeyW + 1;
  localparam int StepsPerCycle = 8;
  localparam int DivCycles     = DivW / StepsPerCycle;

  localparam logic [SizeW-1:0] TableSizeReset = 11'd1024;

  localparam logic [ModeW-1:0] MODE_RETRIEVE = 2'd0;
  localparam logic [ModeW-1:0] MODE_INSERT   = 2'd1;
  localparam logic [ModeW-1:0] MODE_DELETE   = 2'd2;
  localparam logic [ModeW-1:0] MODE_UPDATE   = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [KeyW-1:0]  key;
    logic [KeyW-1:0]  new_key;
    logic [PayW-1:0]  payload;
  } item_t;

  // Number of slots actually in use: zero acts as one, and the size is
  // clipped to the physical table.
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] ts,
                                                input int slots);
    logic [SizeW-1:0] s;
    s = ts;
    if (ts == '0) begin
      s = SizeW'(1);
    end else if (int'(ts) > slots) begin
      s = SizeW'(slots);
    end
    return s;
  endfunction

endpackage

// ===== sv/dmkt_ram.sv =====
module dmkt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dmkt_queue.sv =====
module dmkt_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = $clog2(dmkt_pkg::QDepth);
  localparam int CW = $clog2(dmkt_pkg::QDepth + 1);

  logic [WIDTH-1:0] entries [dmkt_pkg::QDepth];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(dmkt_pkg::QDepth));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(dmkt_pkg::QDepth - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(dmkt_pkg::QDepth - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/dmkt_front.sv =====
module dmkt_front #(
  parameter int SLOTS = dmkt_pkg::SlotsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            hold,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dmkt_pkg::item_t                 item_in,
  input  logic [dmkt_pkg::SizeW-1:0]      table_size,
  output logic                            push,
  input  logic                            q_full,
  output dmkt_pkg::item_t                 push_item,
  output logic [$clog2(SLOTS)-1:0]        push_slot,
  output logic [$clog2(SLOTS)-1:0]        push_new_slot
);

  localparam int IW    = $clog2(SLOTS);
  localparam int SizeW = dmkt_pkg::SizeW;
  localparam int DivW  = dmkt_pkg::DivW;
  localparam int CntW  = $clog2(dmkt_pkg::DivCycles);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic logic [SizeW-1:0] rem_step(input logic [SizeW-1:0] r,
                                                input logic b,
                                                input logic [SizeW-1:0] d);
    logic [SizeW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[SizeW-1:0];
  endfunction

  logic [1:0]       state;
  logic [CntW-1:0]  step_cnt;
  dmkt_pkg::item_t  item;
  logic [DivW-1:0]  div_k;
  logic [DivW-1:0]  div_n;
  logic [SizeW-1:0] rem_k;
  logic [SizeW-1:0] rem_n;
  logic [SizeW-1:0] divisor;
  logic [SizeW-1:0] rem_k_next;
  logic [SizeW-1:0] rem_n_next;
  logic             last_step;
  logic             done_push;
  logic             accept;

  always_comb begin
    rem_k_next = rem_k;
    rem_n_next = rem_n;
    for (int i = 0; i < dmkt_pkg::StepsPerCycle; i++) begin
      rem_k_next = rem_step(rem_k_next, div_k[DivW-1-i], divisor);
      rem_n_next = rem_step(rem_n_next, div_n[DivW-1-i], divisor);
    end
  end

  assign last_step = (state == F_DIV) && (step_cnt == CntW'(dmkt_pkg::DivCycles - 1));
  assign done_push = last_step && !q_full;
  assign push      = done_push || ((state == F_PUSH) && !q_full);
  assign in_stall  = hold || !((state == F_IDLE) || done_push);
  assign accept    = in_valid && !in_stall;

  assign push_item     = item;
  assign push_slot     = (state == F_DIV) ? IW'(rem_k_next) : IW'(rem_k);
  assign push_new_slot = (state == F_DIV) ? IW'(rem_n_next) : IW'(rem_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      step_cnt <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            state    <= F_DIV;
            step_cnt <= '0;
          end
        end
        F_DIV: begin
          if (!last_step) begin
            step_cnt <= step_cnt + CntW'(1);
          end else if (q_full) begin
            state <= F_PUSH;
          end else if (accept) begin
            step_cnt <= '0;
          end else begin
            state <= F_IDLE;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_DIV) begin
      rem_k <= rem_k_next;
      rem_n <= rem_n_next;
      div_k <= div_k << dmkt_pkg::StepsPerCycle;
      div_n <= div_n << dmkt_pkg::StepsPerCycle;
    end
    if (accept) begin
      item    <= item_in;
      div_k   <= {1'b0, item_in.key};
      div_n   <= {1'b0, item_in.new_key};
      rem_k   <= '0;
      rem_n   <= '0;
      divisor <= dmkt_pkg::eff_size(table_size, SLOTS);
    end
  end

endmodule

// ===== sv/dmkt_back.sv =====
module dmkt_back #(
  parameter int SLOTS = dmkt_pkg::SlotsDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [dmkt_pkg::SizeW-1:0]  table_size,
  input  logic                        q_empty,
  output logic                        pop,
  input  dmkt_pkg::item_t             head,
  input  logic [$clog2(SLOTS)-1:0]    head_slot,
  input  logic [$clog2(SLOTS)-1:0]    head_new_slot,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic [dmkt_pkg::PayW-1:0]   payload_out,
  output logic [dmkt_pkg::SizeW-1:0]  occupancy,
  output logic                        full_res
);

  localparam int IW    = $clog2(SLOTS);
  localparam int KeyW  = dmkt_pkg::KeyW;
  localparam int PayW  = dmkt_pkg::PayW;
  localparam int SizeW = dmkt_pkg::SizeW;

  localparam logic [2:0] B_CLEAR = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_EVAL  = 3'd2;
  localparam logic [2:0] B_MOVE  = 3'd3;
  localparam logic [2:0] B_RESP  = 3'd4;

  logic [2:0]       state;
  logic [IW-1:0]    clr_addr;
  logic [SizeW-1:0] count;
  dmkt_pkg::item_t  w_item;
  logic [IW-1:0]    w_slot;
  logic [IW-1:0]    w_new_slot;
  logic             r_found;
  logic [PayW-1:0]  r_pout;
  logic [SizeW-1:0] r_occ;
  logic             r_full;

  logic             k_we;
  logic [IW-1:0]    k_waddr;
  logic [KeyW:0]    k_wdata;
  logic [KeyW:0]    k_rdata;
  logic             p_we;
  logic [IW-1:0]    p_waddr;
  logic [PayW-1:0]  p_rdata;

  logic [SizeW-1:0] eff;
  logic             hit;
  logic [SizeW-1:0] count_next;
  logic             load_out;

  // Key store words carry a valid bit on top of the key.
  dmkt_ram #(.WIDTH(KeyW + 1), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .raddr (head_slot),
    .rdata (k_rdata)
  );

  dmkt_ram #(.WIDTH(PayW), .DEPTH(SLOTS)) u_pay_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (w_item.payload),
    .raddr (head_slot),
    .rdata (p_rdata)
  );

  assign eff      = dmkt_pkg::eff_size(table_size, SLOTS);
  assign hit      = k_rdata[KeyW] && (k_rdata[KeyW-1:0] == w_item.key);
  assign clearing = (state == B_CLEAR);
  assign pop      = (state == B_IDLE) && !q_empty;
  assign load_out = (state == B_RESP) && (!out_valid || !out_stall);

  always_comb begin
    count_next = count;
    if (w_item.mode == dmkt_pkg::MODE_INSERT && count < eff) begin
      count_next = count + SizeW'(1);
    end else if (w_item.mode == dmkt_pkg::MODE_DELETE && count != '0) begin
      count_next = count - SizeW'(1);
    end
  end

  always_comb begin
    k_we    = 1'b0;
    k_waddr = w_slot;
    k_wdata = '0;
    p_we    = 1'b0;
    p_waddr = w_slot;
    unique case (state)
      B_CLEAR: begin
        k_we    = 1'b1;
        k_waddr = clr_addr;
      end
      B_EVAL: begin
        unique case (w_item.mode)
          dmkt_pkg::MODE_RETRIEVE: begin
          end
          dmkt_pkg::MODE_INSERT: begin
            k_we    = 1'b1;
            k_wdata = {1'b1, w_item.key};
            p_we    = 1'b1;
          end
          dmkt_pkg::MODE_DELETE: begin
            k_we = 1'b1;
          end
          dmkt_pkg::MODE_UPDATE: begin
            k_we = hit;
          end
        endcase
      end
      B_MOVE: begin
        k_we    = 1'b1;
        k_waddr = w_new_slot;
        k_wdata = {1'b1, w_item.new_key};
        p_we    = 1'b1;
        p_waddr = w_new_slot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_CLEAR: begin
          if (clr_addr == IW'(SLOTS - 1)) begin
            state <= B_IDLE;
          end else begin
            clr_addr <= clr_addr + IW'(1);
          end
        end
        B_IDLE: begin
          if (pop) begin
            state <= B_EVAL;
          end
        end
        B_EVAL: begin
          count <= count_next;
          if (w_item.mode == dmkt_pkg::MODE_UPDATE && hit) begin
            state <= B_MOVE;
          end else begin
            state <= B_RESP;
          end
        end
        B_MOVE: begin
          state <= B_RESP;
        end
        B_RESP: begin
          if (load_out) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w_item     <= head;
      w_slot     <= head_slot;
      w_new_slot <= head_new_slot;
    end
    if (state == B_EVAL) begin
      r_found <= hit && (w_item.mode == dmkt_pkg::MODE_RETRIEVE ||
                         w_item.mode == dmkt_pkg::MODE_UPDATE);
      r_pout  <= (hit && w_item.mode == dmkt_pkg::MODE_RETRIEVE) ? p_rdata : '0;
      r_occ   <= count_next;
      r_full  <= (count_next >= eff);
    end
    if (load_out) begin
      found       <= r_found;
      payload_out <= r_pout;
      occupancy   <= r_occ;
      full_res    <= r_full;
    end
  end

endmodule

// ===== sv/direct_mapped_key_table.sv =====
// Direct-mapped key table. Each item carries a mode (retrieve, insert,
// delete, update), a key, a replacement key and a 64-bit payload, and it
// produces exactly one result item: found, the payload of a retrieve hit,
// the record count after the operation and a full flag.
// Both channels use valid and stall; an item moves at a rising edge with
// valid high and stall low. The user must write table_size through the APB
// port only while the block is idle; the block itself does not enforce
// this. table_size sets the modulus that maps a key to a slot. The front
// part computes key modulo table size and new_key modulo table size with
// a restoring remainder unit that retires eight bits a cycle; that unit
// bounds the sustained rate, and the front can take a new item in the
// cycle that it pushes the last one into the queue. A two-entry queue
// feeds the back part, which reads the slot, writes it and registers the
// result, with an extra move step for an update that moves a record.
// After reset the back part sweeps the key store to clear every valid
// bit, one slot a cycle, with in_stall held high; register writes are
// taken during the sweep. A stalled result holds in the output register
// while the front keeps working until the queue fills.
module direct_mapped_key_table #(
  parameter int SLOTS = dmkt_pkg::SlotsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmkt_pkg::PaddrW-1:0]  paddr,
  input  logic [dmkt_pkg::DataW-1:0]   pwdata,
  output logic [dmkt_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dmkt_pkg::ModeW-1:0]   mode,
  input  logic [dmkt_pkg::KeyW-1:0]    key,
  input  logic [dmkt_pkg::KeyW-1:0]    new_key,
  input  logic [dmkt_pkg::PayW-1:0]    payload,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic [dmkt_pkg::PayW-1:0]    payload_out,
  output logic [dmkt_pkg::SizeW-1:0]   occupancy,
  output logic                         full_res
);

  localparam int IW = $clog2(SLOTS);
  localparam int QW = $bits(dmkt_pkg::item_t) + 2 * IW;
  localparam int RegIdxW = dmkt_pkg::PaddrW - 2;

  // Register index, taken from the word address.
  localparam logic [RegIdxW-1:0] RegTableSize = '0;

  logic [dmkt_pkg::SizeW-1:0] table_size;
  logic [RegIdxW-1:0]         reg_index;
  logic                       cfg_write;

  dmkt_pkg::item_t            item_in;
  dmkt_pkg::item_t            push_item;
  dmkt_pkg::item_t            head;
  logic [IW-1:0]              push_slot;
  logic [IW-1:0]              push_new_slot;
  logic [IW-1:0]              head_slot;
  logic [IW-1:0]              head_new_slot;
  logic [QW-1:0]              q_out;
  logic                       push;
  logic                       pop;
  logic                       q_full;
  logic                       q_empty;
  logic                       clearing;

  // Configuration port: pready is tied high; one register.
  assign pready    = 1'b1;
  assign reg_index = paddr[dmkt_pkg::PaddrW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (reg_index == RegTableSize) ?
                     dmkt_pkg::DataW'(table_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= dmkt_pkg::TableSizeReset;
    end else if (cfg_write && reg_index == RegTableSize) begin
      table_size <= pwdata[dmkt_pkg::SizeW-1:0];
    end
  end

  assign item_in.mode    = mode;
  assign item_in.key     = key;
  assign item_in.new_key = new_key;
  assign item_in.payload = payload;

  // The front refuses items while the key store is being cleared.
  dmkt_front #(.SLOTS(SLOTS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .hold          (clearing),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .item_in       (item_in),
    .table_size    (table_size),
    .push          (push),
    .q_full        (q_full),
    .push_item     (push_item),
    .push_slot     (push_slot),
    .push_new_slot (push_new_slot)
  );

  dmkt_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_item, push_slot, push_new_slot}),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  assign {head, head_slot, head_new_slot} = q_out;

  dmkt_back #(.SLOTS(SLOTS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .table_size    (table_size),
    .q_empty       (q_empty),
    .pop           (pop),
    .head          (head),
    .head_slot     (head_slot),
    .head_new_slot (head_new_slot),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .payload_out   (payload_out),
    .occupancy     (occupancy),
    .full_res      (full_res)
  );

endmodule

// ===== sv/dmkt_checker.sv =====
module dmkt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        found,
  input logic [dmkt_pkg::PayW-1:0]   payload_out,
  input logic [dmkt_pkg::SizeW-1:0]  occupancy,
  input logic                        full_res
);

  // Reset empties the output and starts the key store sweep.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && in_stall)
    else $error("output valid or input open right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(payload_out) &&
                               $stable(occupancy) && $stable(found))
    else $error("stalled result changed");

  // A result with found low (a miss, an insert or a delete) never returns a payload.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> payload_out == '0)
    else $error("payload returned without a hit");

  // The effective size is at least one, so a full table is never empty.
  a_full_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && full_res |-> occupancy != '0)
    else $error("full flag with zero occupancy");

endmodule

bind direct_mapped_key_table dmkt_checker u_dmkt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .found       (found),
  .payload_out (payload_out),
  .occupancy   (occupancy),
  .full_res    (full_res)
);
